// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RPM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define RPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/rpm_pkg.sv -----
// types, constants and micro-op tables of the relative pose motion block
// no dependencies
package rpm_pkg;

  localparam int unsigned CordicStagesDef = 24;

  localparam int unsigned OpW   = 33;
  localparam int unsigned ProdW = 66;
  localparam int unsigned AccW  = 68;
  localparam int unsigned CxW   = 34;
  localparam int unsigned CzW   = 36;

  localparam logic signed [CzW-1:0] PiQ30     = 36'sd3373259426;
  localparam logic signed [CzW-1:0] HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [CzW-1:0] TwoPiQ30  = 36'sd6746518852;
  localparam logic signed [CxW-1:0] GainQ30   = 34'sd652032874;
  localparam logic signed [OpW-1:0] OneQ30    = 33'sd1073741824;

  // rotation sines and cosines, then the two shared products
  localparam logic [3:0] CsCr = 4'd0;
  localparam logic [3:0] CsSr = 4'd1;
  localparam logic [3:0] CsCp = 4'd2;
  localparam logic [3:0] CsSp = 4'd3;
  localparam logic [3:0] CsCy = 4'd4;
  localparam logic [3:0] CsSy = 4'd5;
  localparam logic [3:0] CsSpsr = 4'd6;
  localparam logic [3:0] CsSpcr = 4'd7;

  localparam logic [3:0] BuildLast = 4'd14;

  typedef struct packed {
    logic              restart;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
    logic signed [19:0] roll;
    logic signed [19:0] pitch;
    logic signed [19:0] yaw;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] rel_r00;
    logic signed [31:0] rel_r01;
    logic signed [31:0] rel_r02;
    logic signed [31:0] rel_r10;
    logic signed [31:0] rel_r11;
    logic signed [31:0] rel_r12;
    logic signed [31:0] rel_r20;
    logic signed [31:0] rel_r21;
    logic signed [31:0] rel_r22;
    logic signed [31:0] rel_tx;
    logic signed [31:0] rel_ty;
    logic signed [31:0] rel_tz;
  } out_word_t;

  typedef enum logic [1:0] {CPH_IDLE, CPH_FOLD, CPH_ITER, CPH_DONE} cph_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_TRIG_GO, ST_TRIG_WAIT, ST_BUILD, ST_REL, ST_TRN, ST_DRAIN, ST_FINISH
  } state_e;

  typedef enum logic [1:0] {PH_BUILD, PH_REL, PH_TRN} mac_phase_e;

  typedef enum logic [2:0] {OG_CS, OG_RN, OG_RP, OG_REL, OG_TP, OG_DIFF, OG_ONE} opnd_grp_e;

  typedef enum logic [1:0] {DG_CS, DG_RN, DG_REL, DG_T} dst_grp_e;

  typedef struct packed {
    opnd_grp_e  grp;
    logic [3:0] idx;
  } opnd_t;

  typedef struct packed {
    opnd_t      a;
    opnd_t      b;
    logic       neg;
    logic       first;
    logic       last;
    logic       trn;
    logic       init_tn;
    dst_grp_e   dgrp;
    logic [3:0] didx;
  } uop_t;

  typedef struct packed {
    logic       load;
    logic       cordic_start;
    logic [1:0] trig_sel;
    logic       issue;
    mac_phase_e phase;
    logic [3:0] step;
    logic [1:0] i;
    logic [1:0] j;
    logic [1:0] k;
    logic       commit;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic cordic_done;
    logic mac_pending;
  } sts_t;

  function automatic logic [30:0] atan_q30(input logic [4:0] idx);
    logic [30:0] v;
    case (idx)
      5'd0:  v = 31'd843314857;
      5'd1:  v = 31'd497837829;
      5'd2:  v = 31'd263043837;
      5'd3:  v = 31'd133525159;
      5'd4:  v = 31'd67021687;
      5'd5:  v = 31'd33543516;
      5'd6:  v = 31'd16775851;
      5'd7:  v = 31'd8388437;
      5'd8:  v = 31'd4194283;
      5'd9:  v = 31'd2097149;
      5'd10: v = 31'd1048576;
      5'd11: v = 31'd524288;
      5'd12: v = 31'd262144;
      5'd13: v = 31'd131072;
      5'd14: v = 31'd65536;
      5'd15: v = 31'd32768;
      5'd16: v = 31'd16384;
      5'd17: v = 31'd8192;
      5'd18: v = 31'd4096;
      5'd19: v = 31'd2048;
      5'd20: v = 31'd1024;
      5'd21: v = 31'd512;
      5'd22: v = 31'd256;
      5'd23: v = 31'd128;
      5'd24: v = 31'd64;
      5'd25: v = 31'd32;
      5'd26: v = 31'd16;
      5'd27: v = 31'd8;
      5'd28: v = 31'd4;
      5'd29: v = 31'd2;
      5'd30: v = 31'd1;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

  // 3*a + b for 3x3 row-major indexing
  function automatic logic [3:0] idx3(input logic [1:0] a, input logic [1:0] b);
    return 4'({a, 1'b0}) + 4'(a) + 4'(b);
  endfunction

  function automatic uop_t mk_uop(input opnd_grp_e ag, input logic [3:0] ai,
                                  input opnd_grp_e bg, input logic [3:0] bi,
                                  input logic neg, input logic first, input logic last,
                                  input dst_grp_e dg, input logic [3:0] di);
    uop_t u;
    u.a.grp = ag;
    u.a.idx = ai;
    u.b.grp = bg;
    u.b.idx = bi;
    u.neg = neg;
    u.first = first;
    u.last = last;
    u.trn = 1'b0;
    u.init_tn = 1'b0;
    u.dgrp = dg;
    u.didx = di;
    return u;
  endfunction

  // products that build R = Rz*Ry*Rx from the sines and cosines
  function automatic uop_t build_uop(input logic [3:0] step);
    uop_t u;
    case (step)
      4'd0:  u = mk_uop(OG_CS, CsSp, OG_CS, CsSr, 1'b0, 1'b1, 1'b1, DG_CS, CsSpsr);
      4'd1:  u = mk_uop(OG_CS, CsSp, OG_CS, CsCr, 1'b0, 1'b1, 1'b1, DG_CS, CsSpcr);
      4'd2:  u = mk_uop(OG_CS, CsCy, OG_CS, CsCp, 1'b0, 1'b1, 1'b1, DG_RN, 4'd0);
      4'd3:  u = mk_uop(OG_CS, CsSy, OG_CS, CsCp, 1'b0, 1'b1, 1'b1, DG_RN, 4'd3);
      4'd4:  u = mk_uop(OG_CS, CsSp, OG_ONE, 4'd0, 1'b1, 1'b1, 1'b1, DG_RN, 4'd6);
      4'd5:  u = mk_uop(OG_CS, CsCp, OG_CS, CsSr, 1'b0, 1'b1, 1'b1, DG_RN, 4'd7);
      4'd6:  u = mk_uop(OG_CS, CsCp, OG_CS, CsCr, 1'b0, 1'b1, 1'b1, DG_RN, 4'd8);
      4'd7:  u = mk_uop(OG_CS, CsCy, OG_CS, CsSpsr, 1'b0, 1'b1, 1'b0, DG_RN, 4'd1);
      4'd8:  u = mk_uop(OG_CS, CsSy, OG_CS, CsCr, 1'b1, 1'b0, 1'b1, DG_RN, 4'd1);
      4'd9:  u = mk_uop(OG_CS, CsCy, OG_CS, CsSpcr, 1'b0, 1'b1, 1'b0, DG_RN, 4'd2);
      4'd10: u = mk_uop(OG_CS, CsSy, OG_CS, CsSr, 1'b0, 1'b0, 1'b1, DG_RN, 4'd2);
      4'd11: u = mk_uop(OG_CS, CsSy, OG_CS, CsSpsr, 1'b0, 1'b1, 1'b0, DG_RN, 4'd4);
      4'd12: u = mk_uop(OG_CS, CsCy, OG_CS, CsCr, 1'b0, 1'b0, 1'b1, DG_RN, 4'd4);
      4'd13: u = mk_uop(OG_CS, CsSy, OG_CS, CsSpcr, 1'b0, 1'b1, 1'b0, DG_RN, 4'd5);
      4'd14: u = mk_uop(OG_CS, CsCy, OG_CS, CsSr, 1'b1, 1'b0, 1'b1, DG_RN, 4'd5);
      default: u = mk_uop(OG_ONE, 4'd0, OG_ONE, 4'd0, 1'b0, 1'b1, 1'b1, DG_CS, CsSpsr);
    endcase
    return u;
  endfunction

  function automatic uop_t mac_uop(input mac_phase_e ph, input logic [3:0] step,
                                   input logic [1:0] i, input logic [1:0] j,
                                   input logic [1:0] k, input logic mode);
    uop_t u;
    u = build_uop(step);
    case (ph)
      PH_BUILD: u = build_uop(step);
      PH_REL: begin
        if (!mode) begin
          u = mk_uop(OG_RN, idx3(k, i), OG_RP, idx3(k, j), 1'b0, k == 2'd0, k == 2'd2,
                     DG_REL, idx3(i, j));
        end else begin
          u = mk_uop(OG_RN, idx3(i, k), OG_RP, idx3(j, k), 1'b0, k == 2'd0, k == 2'd2,
                     DG_REL, idx3(i, j));
        end
      end
      PH_TRN: begin
        if (!mode) begin
          u = mk_uop(OG_RN, idx3(k, i), OG_DIFF, 4'(k), 1'b0, k == 2'd0, k == 2'd2,
                     DG_T, 4'(i));
        end else begin
          u = mk_uop(OG_REL, idx3(i, k), OG_TP, 4'(k), 1'b1, k == 2'd0, k == 2'd2,
                     DG_T, 4'(i));
          u.init_tn = 1'b1;
        end
        u.trn = 1'b1;
      end
      default: u = build_uop(step);
    endcase
    return u;
  endfunction

endpackage

// ----- hdl/rpm_cordic.sv -----
// iterative rotation-mode cordic: one stage per clock, gives cos and sin in q1.30
// depends on rpm_pkg
module rpm_cordic #(
  parameter int unsigned CORDIC_STAGES = rpm_pkg::CordicStagesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [19:0]  angle_i,
  output logic                done_o,
  output logic signed [31:0]  cos_o,
  output logic signed [31:0]  sin_o
);

  localparam int unsigned CntW = $clog2(CORDIC_STAGES);
  localparam logic [CntW-1:0] CntLast = CntW'(CORDIC_STAGES - 1);
  localparam logic signed [rpm_pkg::CxW-1:0] ClampHi = 34'sd1073741824;

  rpm_pkg::cph_e phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic signed [rpm_pkg::CxW-1:0] x_q, x_d, y_q, y_d, xr, yr;
  logic signed [rpm_pkg::CzW-1:0] z_q, z_d, z0, at;
  logic neg_q, neg_d;

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      rpm_pkg::CPH_IDLE: if (start_i) phase_d = rpm_pkg::CPH_FOLD;
      rpm_pkg::CPH_FOLD: phase_d = rpm_pkg::CPH_ITER;
      rpm_pkg::CPH_ITER: if (cnt_q == CntLast) phase_d = rpm_pkg::CPH_DONE;
      rpm_pkg::CPH_DONE: phase_d = rpm_pkg::CPH_IDLE;
      default: phase_d = rpm_pkg::CPH_IDLE;
    endcase
  end

  always_comb begin
    done_o = (phase_q == rpm_pkg::CPH_DONE);
  end

  assign z0 = {{2{angle_i[19]}}, angle_i, 14'b0};
  assign at = $signed({5'b0, rpm_pkg::atan_q30(5'(cnt_q))});

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    neg_d = neg_q;
    cnt_d = cnt_q;
    case (phase_q)
      rpm_pkg::CPH_IDLE: begin
        // one turn brings the angle back into [-pi, pi]
        if (z0 > rpm_pkg::PiQ30) z_d = z0 - rpm_pkg::TwoPiQ30;
        else if (z0 < -rpm_pkg::PiQ30) z_d = z0 + rpm_pkg::TwoPiQ30;
        else z_d = z0;
        x_d = rpm_pkg::GainQ30;
        y_d = '0;
        neg_d = 1'b0;
      end
      rpm_pkg::CPH_FOLD: begin
        // half turn with negated outputs keeps the angle within pi/2
        if (z_q > rpm_pkg::HalfPiQ30) begin
          z_d = z_q - rpm_pkg::PiQ30;
          neg_d = 1'b1;
        end else if (z_q < -rpm_pkg::HalfPiQ30) begin
          z_d = z_q + rpm_pkg::PiQ30;
          neg_d = 1'b1;
        end
        cnt_d = '0;
      end
      rpm_pkg::CPH_ITER: begin
        if (!z_q[rpm_pkg::CzW-1]) begin
          x_d = x_q - (y_q >>> cnt_q);
          y_d = y_q + (x_q >>> cnt_q);
          z_d = z_q - at;
        end else begin
          x_d = x_q + (y_q >>> cnt_q);
          y_d = y_q - (x_q >>> cnt_q);
          z_d = z_q + at;
        end
        cnt_d = cnt_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rpm_pkg::CPH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
    neg_q <= neg_d;
    cnt_q <= cnt_d;
  end

  always_comb begin
    xr = neg_q ? -x_q : x_q;
    yr = neg_q ? -y_q : y_q;
    if (xr > ClampHi) cos_o = 32'(ClampHi);
    else if (xr < -ClampHi) cos_o = 32'(-ClampHi);
    else cos_o = 32'(xr);
    if (yr > ClampHi) sin_o = 32'(ClampHi);
    else if (yr < -ClampHi) sin_o = 32'(-ClampHi);
    else sin_o = 32'(yr);
  end

endmodule

// ----- hdl/rpm_dp.sv -----
// datapath: pose registers, cordic, shared multiply-accumulate and output word
// depends on rpm_pkg and rpm_cordic
module rpm_dp #(
  parameter int unsigned CORDIC_STAGES = rpm_pkg::CordicStagesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rpm_pkg::in_word_t  in_data_i,
  input  logic               cfg_we_i,
  input  logic               cfg_data_i,
  input  rpm_pkg::cmd_t      cmd_i,
  output rpm_pkg::sts_t      sts_o,
  output rpm_pkg::out_word_t out_data_o
);

  localparam logic signed [rpm_pkg::AccW-1:0] RndHalf = 68'sd536870912;
  localparam logic signed [rpm_pkg::AccW-1:0] QOne    = 68'sd1073741824;
  localparam logic signed [rpm_pkg::AccW-1:0] S32Max  = 68'sd2147483647;
  localparam logic signed [rpm_pkg::AccW-1:0] S32Min  = -68'sd2147483648;

  rpm_pkg::in_word_t  in_q;
  rpm_pkg::out_word_t out_q;
  logic mode_q;

  logic signed [31:0] cs_q  [8];
  logic signed [31:0] rn_q  [9];
  logic signed [31:0] rp_q  [9];
  logic signed [31:0] rel_q [9];
  logic signed [31:0] t_q   [3];
  logic signed [31:0] tp_q  [3];
  logic signed [31:0] tn    [3];

  logic signed [19:0] angle;
  logic signed [31:0] cos_w, sin_w;
  logic cordic_done;

  rpm_pkg::uop_t uop, puop_q;
  logic signed [rpm_pkg::OpW-1:0] opa, opb;
  logic signed [rpm_pkg::ProdW-1:0] prod_q;
  logic pvld_q;
  logic signed [rpm_pkg::AccW-1:0] acc_q, p68, prnd, term, prev, sum, rr;
  logic signed [31:0] wb;

  assign tn[0] = in_q.tx;
  assign tn[1] = in_q.ty;
  assign tn[2] = in_q.tz;

  always_comb begin
    case (cmd_i.trig_sel)
      2'd0: angle = in_q.roll;
      2'd1: angle = in_q.pitch;
      default: angle = in_q.yaw;
    endcase
  end

  rpm_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.cordic_start),
    .angle_i (angle),
    .done_o  (cordic_done),
    .cos_o   (cos_w),
    .sin_o   (sin_w)
  );

  assign uop = rpm_pkg::mac_uop(cmd_i.phase, cmd_i.step, cmd_i.i, cmd_i.j, cmd_i.k, mode_q);

  always_comb begin
    case (uop.a.grp)
      rpm_pkg::OG_CS:  opa = 33'(cs_q[uop.a.idx[2:0]]);
      rpm_pkg::OG_RN:  opa = 33'(rn_q[uop.a.idx]);
      rpm_pkg::OG_REL: opa = 33'(rel_q[uop.a.idx]);
      default:         opa = rpm_pkg::OneQ30;
    endcase
  end

  always_comb begin
    case (uop.b.grp)
      rpm_pkg::OG_CS:   opb = 33'(cs_q[uop.b.idx[2:0]]);
      rpm_pkg::OG_RP:   opb = 33'(rp_q[uop.b.idx]);
      rpm_pkg::OG_TP:   opb = 33'(tp_q[uop.b.idx[1:0]]);
      rpm_pkg::OG_DIFF: opb = 33'(tp_q[uop.b.idx[1:0]]) - 33'(tn[uop.b.idx[1:0]]);
      default:          opb = rpm_pkg::OneQ30;
    endcase
  end

  // accumulate stage: rotation sums stay at q.60, translation terms round one by one
  always_comb begin
    p68  = rpm_pkg::AccW'(prod_q);
    prnd = (p68 + RndHalf) >>> 30;
    if (puop_q.trn) term = puop_q.neg ? -prnd : prnd;
    else term = puop_q.neg ? -p68 : p68;
    if (puop_q.first) prev = puop_q.init_tn ? rpm_pkg::AccW'(tn[puop_q.didx[1:0]]) : '0;
    else prev = acc_q;
    sum = prev + term;
    rr = (sum + RndHalf) >>> 30;
    if (puop_q.trn) begin
      if (sum > S32Max) wb = 32'(S32Max);
      else if (sum < S32Min) wb = 32'(S32Min);
      else wb = 32'(sum);
    end else begin
      if (rr > QOne) wb = 32'(QOne);
      else if (rr < -QOne) wb = 32'(-QOne);
      else wb = 32'(rr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      pvld_q <= 1'b0;
      for (int n = 0; n < 9; n++) rp_q[n] <= '0;
      for (int n = 0; n < 3; n++) tp_q[n] <= '0;
    end else begin
      if (cfg_we_i) mode_q <= cfg_data_i;
      pvld_q <= cmd_i.issue;
      if (cmd_i.commit) begin
        for (int n = 0; n < 9; n++) rp_q[n] <= rn_q[n];
        for (int n = 0; n < 3; n++) tp_q[n] <= tn[n];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) in_q <= in_data_i;
    if (cordic_done) begin
      cs_q[{cmd_i.trig_sel, 1'b0}] <= cos_w;
      cs_q[{cmd_i.trig_sel, 1'b1}] <= sin_w;
    end
    if (cmd_i.issue) begin
      prod_q <= opa * opb;
      puop_q <= uop;
    end
    if (pvld_q) begin
      acc_q <= sum;
      if (puop_q.last) begin
        case (puop_q.dgrp)
          rpm_pkg::DG_CS:  cs_q[puop_q.didx[2:0]] <= wb;
          rpm_pkg::DG_RN:  rn_q[puop_q.didx] <= wb;
          rpm_pkg::DG_REL: rel_q[puop_q.didx] <= wb;
          default:         t_q[puop_q.didx[1:0]] <= wb;
        endcase
      end
    end
    if (cmd_i.out_load) begin
      out_q.rel_r00 <= rel_q[0];
      out_q.rel_r01 <= rel_q[1];
      out_q.rel_r02 <= rel_q[2];
      out_q.rel_r10 <= rel_q[3];
      out_q.rel_r11 <= rel_q[4];
      out_q.rel_r12 <= rel_q[5];
      out_q.rel_r20 <= rel_q[6];
      out_q.rel_r21 <= rel_q[7];
      out_q.rel_r22 <= rel_q[8];
      out_q.rel_tx  <= t_q[0];
      out_q.rel_ty  <= t_q[1];
      out_q.rel_tz  <= t_q[2];
    end
  end

  assign sts_o.cordic_done = cordic_done;
  assign sts_o.mac_pending = pvld_q;
  assign out_data_o = out_q;

endmodule

// ----- hdl/rpm_ctrl.sv -----
// controller: sequences the cordic runs and the multiply-accumulate steps
// depends on rpm_pkg
module rpm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_restart_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rpm_pkg::cmd_t cmd_o,
  input  rpm_pkg::sts_t sts_i
);

  rpm_pkg::state_e state_q, state_d;
  logic [1:0] ang_q, ang_d, i_q, i_d, j_q, j_d, k_q, k_d;
  logic [3:0] step_q, step_d;
  logic emit_q, emit_d, have_prev_q, have_prev_d, out_valid_q, out_valid_d;
  logic accept, fire;

  assign accept = in_valid_i && (state_q == rpm_pkg::ST_IDLE);
  // a finished word may leave once the output register is free or being taken
  assign fire = (state_q == rpm_pkg::ST_FINISH) && (!emit_q || !out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      rpm_pkg::ST_IDLE:    if (accept) state_d = rpm_pkg::ST_TRIG_GO;
      rpm_pkg::ST_TRIG_GO: state_d = rpm_pkg::ST_TRIG_WAIT;
      rpm_pkg::ST_TRIG_WAIT: begin
        if (sts_i.cordic_done) begin
          state_d = (ang_q == 2'd2) ? rpm_pkg::ST_BUILD : rpm_pkg::ST_TRIG_GO;
        end
      end
      rpm_pkg::ST_BUILD: begin
        if (step_q == rpm_pkg::BuildLast) begin
          state_d = emit_q ? rpm_pkg::ST_REL : rpm_pkg::ST_DRAIN;
        end
      end
      rpm_pkg::ST_REL: begin
        if (i_q == 2'd2 && j_q == 2'd2 && k_q == 2'd2) state_d = rpm_pkg::ST_TRN;
      end
      rpm_pkg::ST_TRN: if (i_q == 2'd2 && k_q == 2'd2) state_d = rpm_pkg::ST_DRAIN;
      rpm_pkg::ST_DRAIN: if (!sts_i.mac_pending) state_d = rpm_pkg::ST_FINISH;
      rpm_pkg::ST_FINISH: if (fire) state_d = rpm_pkg::ST_IDLE;
      default: state_d = rpm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.load = accept;
    cmd_o.cordic_start = (state_q == rpm_pkg::ST_TRIG_GO);
    cmd_o.trig_sel = ang_q;
    cmd_o.step = step_q;
    cmd_o.i = i_q;
    cmd_o.j = j_q;
    cmd_o.k = k_q;
    cmd_o.commit = fire;
    cmd_o.out_load = fire && emit_q;
    case (state_q)
      rpm_pkg::ST_BUILD: begin
        cmd_o.issue = 1'b1;
        cmd_o.phase = rpm_pkg::PH_BUILD;
      end
      rpm_pkg::ST_REL: begin
        cmd_o.issue = 1'b1;
        cmd_o.phase = rpm_pkg::PH_REL;
      end
      rpm_pkg::ST_TRN: begin
        cmd_o.issue = 1'b1;
        cmd_o.phase = rpm_pkg::PH_TRN;
      end
      default: cmd_o.phase = rpm_pkg::PH_BUILD;
    endcase
  end

  always_comb begin
    ang_d = ang_q;
    step_d = step_q;
    i_d = i_q;
    j_d = j_q;
    k_d = k_q;
    emit_d = emit_q;
    have_prev_d = have_prev_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (accept) begin
      ang_d = '0;
      step_d = '0;
      emit_d = !in_restart_i && have_prev_q;
    end
    if (state_q == rpm_pkg::ST_TRIG_WAIT && sts_i.cordic_done) ang_d = ang_q + 1'b1;
    if (state_q == rpm_pkg::ST_BUILD) begin
      step_d = step_q + 1'b1;
      i_d = '0;
      j_d = '0;
      k_d = '0;
    end
    if (state_q == rpm_pkg::ST_REL) begin
      k_d = (k_q == 2'd2) ? 2'd0 : k_q + 1'b1;
      if (k_q == 2'd2) begin
        j_d = (j_q == 2'd2) ? 2'd0 : j_q + 1'b1;
        if (j_q == 2'd2) i_d = (i_q == 2'd2) ? 2'd0 : i_q + 1'b1;
      end
    end
    if (state_q == rpm_pkg::ST_TRN) begin
      k_d = (k_q == 2'd2) ? 2'd0 : k_q + 1'b1;
      if (k_q == 2'd2) i_d = i_q + 1'b1;
    end
    if (fire) begin
      have_prev_d = 1'b1;
      if (emit_q) out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rpm_pkg::ST_IDLE;
      ang_q <= '0;
      step_q <= '0;
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
      emit_q <= 1'b0;
      have_prev_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ang_q <= ang_d;
      step_q <= step_d;
      i_q <= i_d;
      j_q <= j_d;
      k_q <= k_d;
      emit_q <= emit_d;
      have_prev_q <= have_prev_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o = (state_q != rpm_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- hdl/relative_pose_motion_core.sv -----
// top level of the relative pose motion block: controller plus datapath
// depends on rpm_pkg, rpm_ctrl, rpm_dp, rpm_cordic
// Each input word is a pose (Q16.16 translation, Q3.16 roll/pitch/yaw). The block
// builds R = Rz*Ry*Rx and, from the second pose of a sequence on, outputs the relative
// motion: mode 0 gives inv(T_next)*T_prev, mode 1 gives T_next*inv(T_prev). One word is
// worked on at a time. Sine and cosine come from one shared iterative cordic, run for
// each angle in turn; the matrix products then go through one shared 33x33 multiplier,
// one product a cycle: 15 products to build R, plus 27 for the relative rotation and 9
// for the translation when a word is output. A finished output word waits in its own
// register, so the next input word is taken while it is pending.
module relative_pose_motion_core #(
  parameter int unsigned CORDIC_STAGES = rpm_pkg::CordicStagesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rpm_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rpm_pkg::out_word_t out_data_o,
  input  logic               cfg_we_i,
  input  logic               cfg_data_i
);

  rpm_pkg::cmd_t cmd;
  rpm_pkg::sts_t sts;

  rpm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_restart_i (in_data_i.restart),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cmd_o        (cmd),
    .sts_i        (sts)
  );

  rpm_dp #(.CORDIC_STAGES(CORDIC_STAGES)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

// ----- hdl/rpm_checker.sv -----
// port-level checks of the relative pose motion block, bound to the top level
// depends on rpm_pkg and assert_macros.svh
`include "assert_macros.svh"

module rpm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input rpm_pkg::out_word_t out_data_o
);

  // one word at a time: busy right after taking a word
  `RPM_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  `RPM_ASSERT_NEXT(a_out_held, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  `RPM_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_data_o))

  // the first and last diagonal rotation entries stay within unit magnitude
  `RPM_ASSERT_IMPL(a_rot_range, clk_i, rst_ni, out_valid_o, (out_data_o.rel_r00 <= 32'sd1073741824) && (out_data_o.rel_r00 >= -32'sd1073741824) && (out_data_o.rel_r22 <= 32'sd1073741824) && (out_data_o.rel_r22 >= -32'sd1073741824))

endmodule

bind relative_pose_motion_core rpm_checker u_rpm_checker (.*);
